/* rtl/core/hpil_pkg.sv */
// ----------------------------------------------------------------------------
// hpil_pkg
// Shared types and constants of the hashed path index lookup block.
// ----------------------------------------------------------------------------
package hpil_pkg;

  localparam int ADDR_W       = 9;
  localparam int WORD_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int SLOT_W       = 7;
  localparam int SECTOR_SHIFT = 11;

  localparam logic [WORD_W-1:0] HASH_BASIS  = 32'h811C_9DC5;
  localparam logic [WORD_W-1:0] HASH_PRIME  = 32'h0100_0193;
  localparam logic [WORD_W-1:0] MAGIC_A     = 32'h3232_414E;
  localparam logic [WORD_W-1:0] MAGIC_B     = 32'h5049_5538;
  localparam logic [WORD_W-1:0] ENTRY_BYTES = 32'h0000_0010;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PATH  = 1'b1;

  localparam logic [BYTE_W-1:0] CH_END    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] LOWER_A   = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_Z   = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_GAP  = 8'h20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CMP,
    S_OFS,
    S_LEN,
    S_SIZE,
    S_EMIT
  } search_state_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] count;
  } hdr_status_t;

  typedef struct packed {
    logic              index_valid;
    logic              found;
    logic [SLOT_W-1:0] entry_slot;
    logic [WORD_W-1:0] name_hash;
    logic [WORD_W-1:0] byte_offset;
    logic [WORD_W-1:0] byte_length;
    logic [WORD_W-1:0] unpacked_size;
  } result_t;

  // Backslash becomes slash, lower-case letters become upper case.
  function automatic logic [BYTE_W-1:0] norm_char(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c == CH_BSLASH) begin
      r = CH_SLASH;
    end else if (c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

endpackage

/* rtl/core/hpil_if.sv */
// ----------------------------------------------------------------------------
// hpil_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface hpil_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [hpil_pkg::ADDR_W-1:0]    word_address;
  logic [hpil_pkg::WORD_W-1:0]    word_value;
  logic [hpil_pkg::BYTE_W-1:0]    path_byte;

  modport source (output valid, operation, word_address, word_value, path_byte,
                  input ready);
  modport sink (input valid, operation, word_address, word_value, path_byte,
                output ready);
endinterface

interface hpil_out_if;
  logic                           valid;
  logic                           ready;
  logic                           index_valid;
  logic                           found;
  logic [hpil_pkg::SLOT_W-1:0]    entry_slot;
  logic [hpil_pkg::WORD_W-1:0]    name_hash;
  logic [hpil_pkg::WORD_W-1:0]    byte_offset;
  logic [hpil_pkg::WORD_W-1:0]    byte_length;
  logic [hpil_pkg::WORD_W-1:0]    unpacked_size;

  modport source (output valid, index_valid, found, entry_slot, name_hash,
                  byte_offset, byte_length, unpacked_size, input ready);
  modport sink (input valid, index_valid, found, entry_slot, name_hash,
                byte_offset, byte_length, unpacked_size, output ready);
endinterface

/* rtl/core/hpil_hash.sv */
// ----------------------------------------------------------------------------
// hpil_hash
// Normalizing FNV-1a hash of the path, one byte per cycle.
// ----------------------------------------------------------------------------
module hpil_hash (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        clear,
  input  logic [hpil_pkg::BYTE_W-1:0] path_byte,
  output logic [hpil_pkg::WORD_W-1:0] hash
);
  import hpil_pkg::*;

  logic [WORD_W-1:0] running_hash;
  logic              skipping_leading;
  logic              is_sep;
  logic              skip;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] product;

  always_comb begin
    is_sep  = (path_byte == CH_SLASH) || (path_byte == CH_BSLASH);
    skip    = skipping_leading && is_sep;
    mixed   = running_hash ^ {{(WORD_W-BYTE_W){1'b0}}, norm_char(path_byte)};
    product = mixed * HASH_PRIME;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      running_hash     <= HASH_BASIS;
      skipping_leading <= 1'b1;
    end else if (step && !skip) begin
      running_hash     <= product;
      skipping_leading <= 1'b0;
    end
  end

  assign hash = running_hash;

endmodule

/* rtl/core/hpil_index.sv */
// ----------------------------------------------------------------------------
// hpil_index
// Index word memory with a registered read port, plus the header copy and
// its validity check.
// ----------------------------------------------------------------------------
module hpil_index #(
  parameter int INDEX_WORDS = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [hpil_pkg::ADDR_W-1:0]         wr_addr,
  input  logic [hpil_pkg::WORD_W-1:0]         wr_data,
  input  logic [$clog2(INDEX_WORDS)-1:0]      rd_addr,
  output logic [hpil_pkg::WORD_W-1:0]         rd_data,
  output hpil_pkg::hdr_status_t               hdr
);
  import hpil_pkg::*;

  localparam int AW          = $clog2(INDEX_WORDS);
  localparam int MAX_ENTRIES = (INDEX_WORDS - 4) / 4;

  logic [WORD_W-1:0] mem [INDEX_WORDS];
  logic [WORD_W-1:0] hdr_word [4];
  logic [3:0]        header_written;
  logic              in_range;
  logic              is_header;

  always_comb begin
    in_range  = 32'(wr_addr) < 32'(INDEX_WORDS);
    is_header = (wr_addr[ADDR_W-1:2] == '0);
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      mem[AW'(wr_addr)] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && is_header) begin
      hdr_word[wr_addr[1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_written <= 4'b0000;
    end else if (wr_en && is_header) begin
      header_written[wr_addr[1:0]] <= 1'b1;
    end
  end

  always_comb begin
    hdr.count = hdr_word[2];
    hdr.ok    = (&header_written) &&
                (hdr_word[0] == MAGIC_A) && (hdr_word[1] == MAGIC_B) &&
                (hdr_word[2] != '0) && (hdr_word[2] <= 32'(MAX_ENTRIES)) &&
                (hdr_word[3] == ENTRY_BYTES);
  end

endmodule

/* rtl/core/hpil_search.sv */
// ----------------------------------------------------------------------------
// hpil_search
// Sequencer that walks the entries through the single memory read port and
// one hash comparator, then fetches the matching entry's fields.
// ----------------------------------------------------------------------------
module hpil_search #(
  parameter int INDEX_WORDS = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [hpil_pkg::WORD_W-1:0]         hash,
  input  hpil_pkg::hdr_status_t               hdr,
  input  logic [hpil_pkg::WORD_W-1:0]         rd_data,
  input  logic                                out_free,
  output logic                                ready,
  output logic [$clog2(INDEX_WORDS)-1:0]      rd_addr,
  output logic                                emit,
  output hpil_pkg::result_t                   result
);
  import hpil_pkg::*;

  localparam int AW          = $clog2(INDEX_WORDS);
  localparam int MAX_ENTRIES = (INDEX_WORDS - 4) / 4;
  localparam int KW          = $clog2(MAX_ENTRIES + 1);

  search_state_t     state;
  search_state_t     state_next;
  logic [AW-1:0]     base;
  logic [KW-1:0]     k;
  logic [KW-1:0]     count_q;
  logic [WORD_W-1:0] hash_q;
  logic              valid_q;
  logic              found_q;
  logic [WORD_W-1:0] offset_q;
  logic [WORD_W-1:0] length_q;
  logic [WORD_W-1:0] size_q;
  logic              match;
  logic              last;

  always_comb begin
    match = (rd_data == hash_q);
    last  = (32'(k) + 32'd1) == 32'(count_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) begin
        state_next = hdr.ok ? S_LOOK : S_EMIT;
      end
      S_LOOK: state_next = S_CMP;
      S_CMP: begin
        if (match) begin
          state_next = S_OFS;
        end else if (last) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_LOOK;
        end
      end
      S_OFS:  state_next = S_LEN;
      S_LEN:  state_next = S_SIZE;
      S_SIZE: state_next = S_EMIT;
      S_EMIT: if (out_free) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The read address is set in the state before the one that uses the data.
  always_comb begin
    rd_addr = base;
    ready   = 1'b0;
    emit    = 1'b0;
    unique case (state)
      S_IDLE: ready   = 1'b1;
      S_LOOK: rd_addr = base;
      S_CMP:  rd_addr = base + AW'(1);
      S_OFS:  rd_addr = base + AW'(2);
      S_LEN:  rd_addr = base + AW'(3);
      S_SIZE: rd_addr = base;
      S_EMIT: emit    = out_free;
      default: rd_addr = base;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (start) begin
        hash_q   <= hash;
        valid_q  <= hdr.ok;
        count_q  <= KW'(hdr.count);
        found_q  <= 1'b0;
        offset_q <= '0;
        length_q <= '0;
        size_q   <= '0;
        base     <= AW'(4);
        k        <= '0;
      end
      S_CMP: begin
        if (match) begin
          found_q <= 1'b1;
        end else if (!last) begin
          base <= base + AW'(4);
          k    <= k + KW'(1);
        end
      end
      S_OFS:  offset_q <= rd_data << SECTOR_SHIFT;
      S_LEN:  length_q <= rd_data << SECTOR_SHIFT;
      S_SIZE: size_q   <= rd_data;
      default: ;
    endcase
  end

  always_comb begin
    result.index_valid   = valid_q;
    result.found         = found_q;
    result.entry_slot    = found_q ? SLOT_W'(k) : '0;
    result.name_hash     = hash_q;
    result.byte_offset   = offset_q;
    result.byte_length   = length_q;
    result.unpacked_size = size_q;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("lookup started while a search is running");

  a_found_valid: assert property (@(posedge clk) disable iff (rst)
    emit && result.found |-> result.index_valid)
    else $error("match reported with an invalid index");

  a_slot_in_count: assert property (@(posedge clk) disable iff (rst)
    emit && result.found |-> 32'(k) < 32'(count_q))
    else $error("matching slot beyond the entry count");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK || state == S_CMP || state == S_OFS || state == S_LEN) |->
      32'(rd_addr) < 32'(INDEX_WORDS))
    else $error("entry read beyond the index memory");

endmodule

/* rtl/core/hashed_path_index_lookup.sv */
// ----------------------------------------------------------------------------
// hashed_path_index_lookup
// Pack index store with a normalized FNV-1a path hash and entry search.
// ----------------------------------------------------------------------------
// Usage: items enters on a valid/ready channel. An item with operation 0
// writes word_value into index word word_address (addresses at or beyond
// INDEX_WORDS are dropped). An item with operation 1 feeds path_byte into the
// path hash; a zero byte ends the path and starts a lookup, whose single result
// item leaves on the results channel.
// Writes and non-zero path bytes are accepted back to back while ready is high.
// After the terminator the block drops ready while the sequencer works, since
// all entry words come through one registered memory read port and one
// comparator: an invalid header goes straight to the result, each examined
// entry passes a look and a compare state, and a hit adds offset, length and
// size fetches. The result shows on results in the cycle after it is emitted.
// The result sits in an output register; if the receiver stalls, the block
// holds the search finished until the register frees, and keeps taking items
// once it returns to idle while the previous result still waits.
// Reset clears the hash, the header-written flags and the channels; index
// memory contents are kept undefined until written.
// ----------------------------------------------------------------------------
module hashed_path_index_lookup #(
  parameter int INDEX_WORDS = 512
) (
  input  logic       clk,
  input  logic       rst,
  hpil_in_if.sink    items,
  hpil_out_if.source results
);
  import hpil_pkg::*;

  localparam int AW = $clog2(INDEX_WORDS);

  logic              accept;
  logic              wr_en;
  logic              step;
  logic              start;
  logic [WORD_W-1:0] hash;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  hdr_status_t       hdr;
  logic              search_ready;
  logic              emit;
  logic              out_free;
  result_t           result;
  logic              out_valid;
  result_t           out_q;

  always_comb begin
    accept   = items.valid && items.ready;
    wr_en    = accept && (items.operation == OP_WRITE);
    step     = accept && (items.operation == OP_PATH) && (items.path_byte != CH_END);
    start    = accept && (items.operation == OP_PATH) && (items.path_byte == CH_END);
    out_free = !out_valid || results.ready;
  end

  assign items.ready = search_ready;

  hpil_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .clear     (start),
    .path_byte (items.path_byte),
    .hash      (hash)
  );

  hpil_index #(.INDEX_WORDS(INDEX_WORDS)) u_index (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (items.word_address),
    .wr_data (items.word_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .hdr     (hdr)
  );

  hpil_search #(.INDEX_WORDS(INDEX_WORDS)) u_search (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .hash     (hash),
    .hdr      (hdr),
    .rd_data  (rd_data),
    .out_free (out_free),
    .ready    (search_ready),
    .rd_addr  (rd_addr),
    .emit     (emit),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_q <= result;
    end
  end

  assign results.valid         = out_valid;
  assign results.index_valid   = out_q.index_valid;
  assign results.found         = out_q.found;
  assign results.entry_slot    = out_q.entry_slot;
  assign results.name_hash     = out_q.name_hash;
  assign results.byte_offset   = out_q.byte_offset;
  assign results.byte_length   = out_q.byte_length;
  assign results.unpacked_size = out_q.unpacked_size;

endmodule
